### rtl/core/rational_arith_unit_macros.svh
// ----------------------------------------------------------------------------
// Rational arithmetic unit assertion macros
// Shorthand for the concurrent assertions of the checker, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITH_UNIT_MACROS_SVH
`define RATIONAL_ARITH_UNIT_MACROS_SVH

// Assertion that is switched off while reset is high.
`define RAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that is checked at every edge, reset included.
`define RAU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/rau_pkg.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Widths, operation codes and the structs shared by the unit's modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rau_pkg;

  localparam int OPERAND_BITS = 16;
  localparam int KIND_W       = 3;
  localparam int PROD_W       = 2 * OPERAND_BITS;
  localparam int SUM_W        = PROD_W + 1;
  localparam int DIV_W        = PROD_W;
  localparam int DIV_CNT_W    = $clog2(DIV_W);
  localparam int RES_NUM_W    = 32;
  localparam int RES_DEN_W    = 31;

  localparam logic [KIND_W-1:0] KIND_ADD    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SUB    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_GT     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_EQ     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_REDUCE = 3'd4;

  typedef struct packed {
    logic [KIND_W-1:0]              kind;
    logic signed [OPERAND_BITS-1:0] a_num;
    logic signed [OPERAND_BITS-1:0] a_den;
    logic signed [OPERAND_BITS-1:0] b_num;
    logic signed [OPERAND_BITS-1:0] b_den;
  } op_t;

  typedef struct packed {
    logic signed [RES_NUM_W-1:0] res_num;
    logic [RES_DEN_W-1:0]        res_den;
    logic                        flag;
    logic                        error;
  } res_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [DIV_W-1:0] remainder;
  } div_rsp_t;

endpackage

### rtl/core/rational_arith_unit.sv
// Rational arithmetic unit: each transfer on the op channel carries two
// fractions a and b and an operation kind (add, subtract, greater than, equal,
// reduce a), and yields exactly one transfer on the res channel. Add, subtract
// and reduce return the fraction in lowest terms with a positive denominator;
// greater than and equal return their outcome in flag with 0/1 as the
// fraction. A used denominator of zero or less, or an unknown kind, returns
// 0/1 with error set. The unit works on one operation at a time and drops
// op_ready from the transfer until the result has moved into the output
// register, which then lets the next operation in while the result waits.
// Equal and error cases finish from the check state, and greater than uses
// the multiplier only. Add, subtract and reduce also run the shared 32-bit
// restoring divider, once for each Euclid remainder step of the GCD and
// then once each for the numerator and the denominator.
// ----------------------------------------------------------------------------
// Rational arithmetic unit top level
// Handshake, output register, sequencer and shared divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rational_arith_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           op_valid,
  output logic           op_ready,
  input  rau_pkg::op_t   op_data,
  output logic           res_valid,
  input  logic           res_ready,
  output rau_pkg::res_t  res_data
);

  logic              core_ready;
  logic              core_valid;
  logic              core_take;
  rau_pkg::res_t     core_res;
  rau_pkg::div_req_t div_req;
  rau_pkg::div_rsp_t div_rsp;

  // The sequencer takes a new operation only from its idle state.
  assign op_ready = core_ready;

  // A finished result moves into the output register whenever that register
  // is empty or its contents leave in the same cycle.
  assign core_take = core_valid && (!res_valid || res_ready);

  rau_core u_core (
    .clk     (clk),
    .rst     (rst),
    .start   (op_valid && core_ready),
    .op      (op_data),
    .ready   (core_ready),
    .valid   (core_valid),
    .res     (core_res),
    .take    (core_take),
    .div_req (div_req),
    .div_rsp (div_rsp)
  );

  // The divider serves both the Euclid remainder steps and the final
  // divisions of numerator and denominator by the GCD.
  rau_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Output register: holds one result until its transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      if (core_take) begin
        res_valid <= 1'b1;
        res_data  <= core_res;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/core/rau_divider.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rau_divider (
  input  logic               clk,
  input  logic               rst,
  input  rau_pkg::div_req_t  req,
  output rau_pkg::div_rsp_t  rsp
);

  logic                          busy;
  logic                          done;
  logic [rau_pkg::DIV_CNT_W-1:0] cnt;
  logic [rau_pkg::DIV_W-1:0]     rem;
  logic [rau_pkg::DIV_W-1:0]     quo;
  logic [rau_pkg::DIV_W-1:0]     dvs;
  logic [rau_pkg::DIV_W:0]       shifted;
  logic [rau_pkg::DIV_W:0]       diff;

  // Bring down the next dividend bit and try to subtract the divisor.
  assign shifted = {rem, quo[rau_pkg::DIV_W-1]};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= req.dividend;
        dvs  <= req.divisor;
      end else if (busy) begin
        if (!diff[rau_pkg::DIV_W]) begin
          rem <= diff[rau_pkg::DIV_W-1:0];
          quo <= {quo[rau_pkg::DIV_W-2:0], 1'b1};
        end else begin
          rem <= shifted[rau_pkg::DIV_W-1:0];
          quo <= {quo[rau_pkg::DIV_W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == rau_pkg::DIV_CNT_W'(rau_pkg::DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    rsp.done      = done;
    rsp.quotient  = quo;
    rsp.remainder = rem;
  end

endmodule

### rtl/core/rau_core.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit sequencer
// Runs one operation through the shared multiplier and the shared divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rau_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  rau_pkg::op_t       op,
  output logic               ready,
  output logic               valid,
  output rau_pkg::res_t      res,
  input  logic               take,
  output rau_pkg::div_req_t  div_req,
  input  rau_pkg::div_rsp_t  div_rsp
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_MUL0, S_MUL1, S_MUL2, S_COMB,
    S_GCD, S_GWAIT, S_QNUM, S_QDEN, S_DONE
  } state_t;

  state_t                                state;
  rau_pkg::op_t                          opr;
  logic signed [rau_pkg::OPERAND_BITS-1:0] mul_a;
  logic signed [rau_pkg::OPERAND_BITS-1:0] mul_b;
  logic signed [rau_pkg::PROD_W-1:0]     mul_p;
  logic signed [rau_pkg::PROD_W-1:0]     p_an_bd;
  logic signed [rau_pkg::PROD_W-1:0]     p_ad_bn;
  logic signed [rau_pkg::PROD_W-1:0]     p_ad_bd;
  logic signed [rau_pkg::SUM_W-1:0]      sum;
  logic signed [rau_pkg::DIV_W-1:0]      an_ext;
  logic [rau_pkg::DIV_W-1:0]             an_mag;
  logic [rau_pkg::DIV_W-1:0]             sum_mag;
  logic [rau_pkg::DIV_W-1:0]             mag;
  logic [rau_pkg::DIV_W-1:0]             den;
  logic [rau_pkg::DIV_W-1:0]             gx;
  logic [rau_pkg::DIV_W-1:0]             gy;
  logic [rau_pkg::DIV_W-1:0]             num_q;
  logic                                  neg;
  logic                                  den_bad;

  // One signed multiplier, fed a different operand pair in each product state.
  always_comb begin
    case (state)
      S_MUL0: begin
        mul_a = opr.a_num;
        mul_b = opr.b_den;
      end
      S_MUL1: begin
        mul_a = opr.a_den;
        mul_b = opr.b_num;
      end
      default: begin
        mul_a = opr.a_den;
        mul_b = opr.b_den;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign sum = (opr.kind == rau_pkg::KIND_SUB)
             ? rau_pkg::SUM_W'(p_an_bd) - rau_pkg::SUM_W'(p_ad_bn)
             : rau_pkg::SUM_W'(p_an_bd) + rau_pkg::SUM_W'(p_ad_bn);
  assign sum_mag = sum[rau_pkg::SUM_W-1] ? rau_pkg::DIV_W'(-sum) : rau_pkg::DIV_W'(sum);

  assign an_ext = rau_pkg::DIV_W'(opr.a_num);
  assign an_mag = opr.a_num[rau_pkg::OPERAND_BITS-1] ? -an_ext : an_ext;

  // A denominator of zero or below is rejected; reduce looks at a alone.
  assign den_bad = opr.a_den[rau_pkg::OPERAND_BITS-1] || (opr.a_den == '0) ||
                   ((opr.kind != rau_pkg::KIND_REDUCE) &&
                    (opr.b_den[rau_pkg::OPERAND_BITS-1] || (opr.b_den == '0)));

  // Divider requests: Euclid steps, then the two divisions by the GCD.
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = gx;
    div_req.divisor  = gy;
    case (state)
      S_GCD: begin
        div_req.start = 1'b1;
        if (gy == '0) begin
          div_req.dividend = mag;
          div_req.divisor  = gx;
        end
      end
      S_QNUM: begin
        div_req.start    = div_rsp.done;
        div_req.dividend = den;
        div_req.divisor  = gx;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  assign ready = (state == S_IDLE);
  assign valid = (state == S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            opr   <= op;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          res.res_num <= '0;
          res.res_den <= rau_pkg::RES_DEN_W'(1);
          res.flag    <= 1'b0;
          res.error   <= 1'b0;
          if (den_bad) begin
            res.error <= 1'b1;
            state     <= S_DONE;
          end else begin
            case (opr.kind)
              rau_pkg::KIND_ADD, rau_pkg::KIND_SUB, rau_pkg::KIND_GT: begin
                state <= S_MUL0;
              end
              rau_pkg::KIND_EQ: begin
                res.flag <= (opr.a_num == opr.b_num) && (opr.a_den == opr.b_den);
                state    <= S_DONE;
              end
              rau_pkg::KIND_REDUCE: begin
                mag   <= an_mag;
                neg   <= opr.a_num[rau_pkg::OPERAND_BITS-1];
                den   <= rau_pkg::DIV_W'($unsigned(opr.a_den));
                gx    <= an_mag;
                gy    <= rau_pkg::DIV_W'($unsigned(opr.a_den));
                state <= S_GCD;
              end
              default: begin
                res.error <= 1'b1;
                state     <= S_DONE;
              end
            endcase
          end
        end
        S_MUL0: begin
          p_an_bd <= mul_p;
          state   <= S_MUL1;
        end
        S_MUL1: begin
          p_ad_bn <= mul_p;
          state   <= S_MUL2;
        end
        S_MUL2: begin
          p_ad_bd <= mul_p;
          state   <= S_COMB;
        end
        S_COMB: begin
          if (opr.kind == rau_pkg::KIND_GT) begin
            res.flag <= (p_an_bd > p_ad_bn);
            state    <= S_DONE;
          end else begin
            mag   <= sum_mag;
            neg   <= sum[rau_pkg::SUM_W-1];
            den   <= rau_pkg::DIV_W'($unsigned(p_ad_bd));
            gx    <= sum_mag;
            gy    <= rau_pkg::DIV_W'($unsigned(p_ad_bd));
            state <= S_GCD;
          end
        end
        S_GCD: begin
          state <= (gy == '0) ? S_QNUM : S_GWAIT;
        end
        S_GWAIT: begin
          if (div_rsp.done) begin
            gx    <= gy;
            gy    <= div_rsp.remainder;
            state <= S_GCD;
          end
        end
        S_QNUM: begin
          if (div_rsp.done) begin
            num_q <= div_rsp.quotient;
            state <= S_QDEN;
          end
        end
        S_QDEN: begin
          if (div_rsp.done) begin
            res.res_num <= neg ? -rau_pkg::RES_NUM_W'(num_q) : rau_pkg::RES_NUM_W'(num_q);
            res.res_den <= rau_pkg::RES_DEN_W'(div_rsp.quotient);
            state       <= S_DONE;
          end
        end
        S_DONE: begin
          if (take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/core/rau_checker.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit checker
// Port-level assertions on the unit, attached to the top level by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rational_arith_unit_macros.svh"

module rau_checker (
  input logic          clk,
  input logic          rst,
  input logic          op_valid,
  input logic          op_ready,
  input rau_pkg::op_t  op_data,
  input logic          res_valid,
  input logic          res_ready,
  input rau_pkg::res_t res_data
);

  `RAU_ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> !res_valid, "result valid after reset")
  `RAU_ASSERT(a_one_at_a_time, op_valid && op_ready |=> !op_ready, "second operation taken at once")
  `RAU_ASSERT(a_res_hold, res_valid && !res_ready |=> res_valid && $stable(res_data), "stalled result changed")
  `RAU_ASSERT(a_error_zero, res_valid && res_data.error |-> res_data.res_num == 0 && res_data.res_den == 1 && !res_data.flag, "error result is not zero over one")
  `RAU_ASSERT(a_den_nonzero, res_valid |-> res_data.res_den != 0, "zero denominator delivered")

endmodule

bind rational_arith_unit rau_checker u_rau_checker (.*);
